>>> rtl/core/ldes_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ldes_pkg;

  localparam int unsigned CRED_W  = 32;
  localparam int unsigned TIME_W  = 63;
  localparam int unsigned ID_W    = 32;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_INELIGIBLE_CRED = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INVALID_ID      = 1'd1;

  localparam logic [CRED_W-1:0] INELIGIBLE_CRED_RESET = '0;
  localparam logic [ID_W-1:0]   INVALID_ID_RESET      = '1;

  typedef struct packed {
    logic [CRED_W-1:0] credential;
    logic [TIME_W-1:0] boot_time;
    logic [ID_W-1:0]   id;
  } member_t;

  typedef struct packed {
    logic [ID_W-1:0] leader_id;
    logic [ID_W-1:0] deputy_id;
    logic            leader_found;
    logic            deputy_found;
  } result_t;

  // True when member a outranks member b: higher credential, or an equal
  // credential with an earlier boot time.
  function automatic logic outranks(member_t a, member_t b);
    outranks = (a.credential > b.credential) ||
               ((a.credential == b.credential) && (a.boot_time < b.boot_time));
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/leader_deputy_election_select_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Picks a leader and a deputy from a list of cluster members, one member per
// item, and delivers one result item after the item that carries the last
// member mark. A member item is accepted in every cycle while input ready
// is high; the running leader and deputy registers are updated by a few
// compares in the same cycle, and the result is registered into the output
// buffer when the last member is accepted. A two-entry output buffer lets
// member items keep flowing while a result waits to be taken; input ready
// drops only when both entries hold results. Configuration writes take
// effect on the next cycle and must be made while the block is idle.
module leader_deputy_election_select_unit
  import ldes_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,

  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,

  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [CRED_W-1:0]    credential,
  input  wire logic [TIME_W-1:0]    boot_time,
  input  wire logic [ID_W-1:0]      member_id,
  input  wire logic                 last_member,
  input  wire logic                 change_kind_ok,

  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [ID_W-1:0]           leader_id,
  output logic [ID_W-1:0]           deputy_id,
  output logic                      leader_found,
  output logic                      deputy_found
);

  logic [CRED_W-1:0] ineligible_cred;
  logic [ID_W-1:0]   invalid_id;

  logic    have_leader;
  logic    have_deputy;
  member_t best;
  member_t second;

  logic    have_leader_next;
  logic    have_deputy_next;
  member_t best_next;
  member_t second_next;

  member_t cand;
  logic    eligible;
  logic    accept;
  logic    push;
  logic    pop;
  result_t result_next;

  result_t out_data;
  result_t skid_data;
  logic    skid_valid;

  assign in_ready = !skid_valid;
  assign accept   = in_valid && in_ready;
  assign push     = accept && last_member;
  assign pop      = out_valid && out_ready;

  assign cand.credential = credential;
  assign cand.boot_time  = boot_time;
  assign cand.id         = member_id;
  assign eligible        = (credential != ineligible_cred);

  always_comb begin
    have_leader_next = have_leader;
    have_deputy_next = have_deputy;
    best_next        = best;
    second_next      = second;
    if (eligible) begin
      if (!have_leader) begin
        best_next        = cand;
        have_leader_next = 1'b1;
      end else if (!have_deputy) begin
        have_deputy_next = 1'b1;
        if (outranks(cand, best)) begin
          second_next = best;
          best_next   = cand;
        end else begin
          second_next = cand;
        end
      end else if (outranks(cand, best)) begin
        second_next = best;
        best_next   = cand;
      end else if ((cand.credential < best.credential) &&
                   (cand.credential > second.credential)) begin
        second_next = cand;
      end
    end
  end

  always_comb begin
    if (change_kind_ok && have_leader_next) begin
      result_next.leader_id    = best_next.id;
      result_next.leader_found = 1'b1;
    end else begin
      result_next.leader_id    = invalid_id;
      result_next.leader_found = 1'b0;
    end
    if (change_kind_ok && have_deputy_next) begin
      result_next.deputy_id    = second_next.id;
      result_next.deputy_found = 1'b1;
    end else begin
      result_next.deputy_id    = invalid_id;
      result_next.deputy_found = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ineligible_cred <= INELIGIBLE_CRED_RESET;
      invalid_id      <= INVALID_ID_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INELIGIBLE_CRED: ineligible_cred <= cfg_data[CRED_W-1:0];
        REG_INVALID_ID:      invalid_id      <= cfg_data[ID_W-1:0];
        default: ;
      endcase
    end
  end

  // The running leader and deputy are cleared after each last member.
  always_ff @(posedge clk) begin
    if (rst) begin
      have_leader <= 1'b0;
      have_deputy <= 1'b0;
    end else if (accept) begin
      have_leader <= have_leader_next && !last_member;
      have_deputy <= have_deputy_next && !last_member;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      best   <= best_next;
      second <= second_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else if (push) begin
        out_data <= result_next;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid) begin
        out_data  <= result_next;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= result_next;
        skid_valid <= 1'b1;
      end
    end
  end

  assign leader_id    = out_data.leader_id;
  assign deputy_id    = out_data.deputy_id;
  assign leader_found = out_data.leader_found;
  assign deputy_found = out_data.deputy_found;

endmodule

`default_nettype wire
